### design/lcmc_pkg.sv
// Shared types, reset values and event codes for the curtain motor controller.
// No dependencies; every other design file imports this package.
`default_nettype none

package lcmc_pkg;

  // Width of the elapsed-time counter.
  localparam int TIME_BITS = 20;
  // Width used for time compares: wide enough for the time counter and the
  // 20-bit run-time registers.
  localparam int CMP_BITS = (TIME_BITS > 20) ? TIME_BITS : 20;
  localparam int CFG_BITS = 20;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LIGHT_THRESHOLD = 3'd0,
    REG_LIGHT_CONFIRM   = 3'd1,
    REG_MIN_GAP         = 3'd2,
    REG_MAX_RUN         = 3'd3,
    REG_MIN_RUN         = 3'd4,
    REG_WRONG_DIR       = 3'd5,
    REG_END_CONFIRM     = 3'd6
  } reg_idx_t;

  // Stop and start causes reported with each result word.
  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_START_CLOSE = 3'd1,
    EV_START_OPEN  = 3'd2,
    EV_DONE        = 3'd3,
    EV_WRONG_DIR   = 3'd4,
    EV_TIMEOUT     = 3'd5
  } event_t;

  typedef struct packed {
    logic [7:0] light_level;
    logic       end_reached;
  } item_t;

  typedef struct packed {
    logic       drive_close;
    logic       drive_open;
    logic       fault_led;
    logic [2:0] event_code;
  } result_t;

  typedef struct packed {
    logic [7:0]  light_threshold;
    logic [7:0]  light_confirm_ticks;
    logic [15:0] min_gap_ticks;
    logic [19:0] max_run_ticks;
    logic [19:0] min_run_ticks;
    logic [7:0]  wrong_dir_confirm;
    logic [7:0]  end_confirm;
  } cfg_t;

  typedef struct packed {
    logic                 night_mode;
    logic                 motor_running;
    logic                 known_open;
    logic                 known_closed;
    logic                 faulted;
    logic [7:0]           night_count;
    logic [7:0]           day_count;
    logic [TIME_BITS-1:0] since_start;
    logic [7:0]           early_hits;
    logic [7:0]           late_hits;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    light_threshold:     8'd50,
    light_confirm_ticks: 8'd8,
    min_gap_ticks:       16'd12,
    max_run_ticks:       20'd480,
    min_run_ticks:       20'd120,
    wrong_dir_confirm:   8'd8,
    end_confirm:         8'd1
  };

  localparam state_t STATE_RESET = '{
    night_mode:    1'b0,
    motor_running: 1'b0,
    known_open:    1'b0,
    known_closed:  1'b0,
    faulted:       1'b0,
    night_count:   8'd0,
    day_count:     8'd0,
    since_start:   {TIME_BITS{1'b1}},
    early_hits:    8'd0,
    late_hits:     8'd0
  };

  // Increment that sticks at 255.
  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

### design/light_driven_curtain_motor_control.sv
// Top level of the light-driven curtain motor controller: config registers,
// controller state and output register. Uses lcmc_pkg and lcmc_step.
//
// Each input word is one timer tick and yields exactly one result word. A
// word is accepted every cycle while the output register is empty or being
// taken; its result appears in the output register in the cycle after
// acceptance. The whole tick update is one combinational pass over the
// controller state, so throughput is one word per cycle while the output is
// not stalled. Config writes take effect on the next tick.
`default_nettype none

module light_driven_curtain_motor_control (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       item_valid,
  output logic                      item_stall,
  input  lcmc_pkg::item_t           item,
  output logic                      result_valid,
  input  wire                       result_stall,
  output lcmc_pkg::result_t         result,
  input  wire                       cfg_we,
  input  wire [2:0]                 cfg_index,
  input  wire [lcmc_pkg::CFG_BITS-1:0] cfg_data
);
  import lcmc_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t step_res;
  logic    item_take;

  assign item_stall = result_valid && result_stall;
  assign item_take  = item_valid && !item_stall;

  lcmc_step u_step (
    .cur  (state),
    .cfg  (cfg),
    .item (item),
    .nxt  (state_next),
    .res  (step_res)
  );

  // Config register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LIGHT_THRESHOLD: cfg.light_threshold     <= cfg_data[7:0];
        REG_LIGHT_CONFIRM:   cfg.light_confirm_ticks <= cfg_data[7:0];
        REG_MIN_GAP:         cfg.min_gap_ticks       <= cfg_data[15:0];
        REG_MAX_RUN:         cfg.max_run_ticks       <= cfg_data[19:0];
        REG_MIN_RUN:         cfg.min_run_ticks       <= cfg_data[19:0];
        REG_WRONG_DIR:       cfg.wrong_dir_confirm   <= cfg_data[7:0];
        REG_END_CONFIRM:     cfg.end_confirm         <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Controller state advances once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (item_take) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      result <= step_res;
    end
  end

endmodule

`default_nettype wire

### design/lcmc_step.sv
// Next-state and result logic for one tick of the curtain motor controller.
// Purely combinational; uses lcmc_pkg types and helpers.
`default_nettype none

module lcmc_step (
  input  lcmc_pkg::state_t  cur,
  input  lcmc_pkg::cfg_t    cfg,
  input  lcmc_pkg::item_t   item,
  output lcmc_pkg::state_t  nxt,
  output lcmc_pkg::result_t res
);
  import lcmc_pkg::*;

  logic [TIME_BITS-1:0] since_inc;
  logic [CMP_BITS-1:0]  dur;
  logic [CMP_BITS-1:0]  max_run;
  logic [CMP_BITS-1:0]  min_run;
  logic [CMP_BITS-1:0]  min_gap;
  logic [7:0]           early_inc;
  logic [7:0]           late_inc;
  logic                 early_stop;
  logic                 night_seen;
  event_t               ev;

  // Elapsed time advances every tick, saturating.
  assign since_inc  = (&cur.since_start) ? cur.since_start
                                         : cur.since_start + TIME_BITS'(1);
  assign dur        = CMP_BITS'(since_inc);
  assign max_run    = CMP_BITS'(cfg.max_run_ticks);
  assign min_run    = CMP_BITS'(cfg.min_run_ticks);
  assign min_gap    = CMP_BITS'(cfg.min_gap_ticks);
  assign early_inc  = sat_inc8(cur.early_hits);
  assign late_inc   = sat_inc8(cur.late_hits);
  assign night_seen = item.light_level > cfg.light_threshold;
  assign early_stop = early_inc > cfg.wrong_dir_confirm;

  always_comb begin
    nxt             = cur;
    nxt.since_start = since_inc;
    ev              = EV_NONE;
    if (cur.faulted) begin
      // latched fault: only time advances
    end else if (cur.motor_running) begin
      if (dur > max_run) begin
        nxt.motor_running = 1'b0;
        nxt.known_closed  = cur.night_mode;
        nxt.known_open    = !cur.night_mode;
        nxt.faulted       = 1'b1;
        ev                = EV_TIMEOUT;
      end else begin
        // early switch with unknown position: wrong direction
        if (!cur.known_open && !cur.known_closed && dur < min_run && item.end_reached) begin
          nxt.early_hits = early_inc;
          if (early_stop) begin
            nxt.motor_running = 1'b0;
            nxt.known_closed  = cur.night_mode;
            nxt.known_open    = !cur.night_mode;
            ev                = EV_WRONG_DIR;
          end
        end
        // late switch: travel done
        if (ev == EV_NONE && dur > min_run && item.end_reached) begin
          nxt.late_hits = late_inc;
          if (late_inc > cfg.end_confirm) begin
            nxt.motor_running = 1'b0;
            nxt.known_closed  = cur.night_mode;
            nxt.known_open    = !cur.night_mode;
            ev                = EV_DONE;
          end
        end
      end
    end else if (CMP_BITS'(since_inc) >= min_gap) begin
      // idle: count toward night or day, start on confirm
      if (night_seen) begin
        nxt.day_count = 8'd0;
        if (!cur.known_closed) begin
          if (cur.night_count >= cfg.light_confirm_ticks) begin
            nxt.motor_running = 1'b1;
            nxt.night_mode    = 1'b1;
            nxt.since_start   = '0;
            nxt.early_hits    = 8'd0;
            nxt.late_hits     = 8'd0;
            ev                = EV_START_CLOSE;
          end else begin
            nxt.night_count = sat_inc8(cur.night_count);
          end
        end
      end else begin
        nxt.night_count = 8'd0;
        if (!cur.known_open) begin
          if (cur.day_count >= cfg.light_confirm_ticks) begin
            nxt.motor_running = 1'b1;
            nxt.night_mode    = 1'b0;
            nxt.since_start   = '0;
            nxt.early_hits    = 8'd0;
            nxt.late_hits     = 8'd0;
            ev                = EV_START_OPEN;
          end else begin
            nxt.day_count = sat_inc8(cur.day_count);
          end
        end
      end
    end
  end

  // Result reflects the state after the tick.
  always_comb begin
    res.drive_close = nxt.motor_running && nxt.night_mode;
    res.drive_open  = nxt.motor_running && !nxt.night_mode;
    res.fault_led   = nxt.faulted;
    res.event_code  = ev;
  end

endmodule

`default_nettype wire

### design/lcmc_checker.sv
// Port-level checks for the curtain motor controller, bound to the top level.
// Uses lcmc_pkg for the event codes.
`default_nettype none

module lcmc_checker (
  input wire                clk,
  input wire                rst,
  input wire                result_valid,
  input wire                result_stall,
  input lcmc_pkg::result_t  result
);
  import lcmc_pkg::*;

  // The motor is never driven both ways.
  a_one_dir: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.drive_close && result.drive_open))
    else $error("both drive lines high");

  // A latched fault keeps the motor off.
  a_fault_off: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.fault_led) |-> (!result.drive_close && !result.drive_open))
    else $error("motor driven while faulted");

  // A start event comes with the matching drive line.
  a_start_drive: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.event_code == EV_START_CLOSE ||
                      result.event_code == EV_START_OPEN)) |->
    ((result.event_code == EV_START_CLOSE) ? result.drive_close : result.drive_open))
    else $error("start event without drive");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind light_driven_curtain_motor_control lcmc_checker u_lcmc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

### dv/tb_light_driven_curtain_motor_control.sv
// Testbench for the light-driven curtain motor controller: a queue-fed driver, a result
// monitor and a tick-accurate predictor of the tick update, checked word by word.
// Depends on lcmc_pkg and light_driven_curtain_motor_control.
`default_nettype none

module tb_light_driven_curtain_motor_control;
  import lcmc_pkg::*;

  // Config index that decodes to no register; writes to it must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic item_valid = 1'b0;
  logic item_stall;
  item_t tick_word = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result_word;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  light_driven_curtain_motor_control dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (tick_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted controller state and register copy
  cfg_t model_cfg;
  logic closing_night, motor_on, at_open, at_closed, fault_latched;
  logic [7:0] dark_ticks, day_cnt, early_cnt, late_cnt;
  logic [TIME_BITS-1:0] elapsed;

  item_t   pending_ticks[$];
  result_t expected_results[$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned event_seen[6];
  int unsigned settings_used = 0;

  function automatic void halt_run();
    motor_on  = 1'b0;
    at_closed = closing_night;
    at_open   = !closing_night;
  endfunction

  function automatic void start_motor(input logic night);
    motor_on      = 1'b1;
    closing_night = night;
    elapsed       = '0;
    early_cnt     = '0;
    late_cnt      = '0;
  endfunction

  // One timer tick of the controller; returns the word it reports.
  function automatic result_t curtain_tick(input item_t w);
    event_t ev;
    result_t r;
    ev = EV_NONE;
    if (elapsed != {TIME_BITS{1'b1}}) elapsed = elapsed + TIME_BITS'(1);

    if (fault_latched) begin
      // latched: only the time counter moves
    end else if (motor_on) begin
      if (elapsed > model_cfg.max_run_ticks) begin
        halt_run();
        fault_latched = 1'b1;
        ev = EV_TIMEOUT;
      end else begin
        // early switch with no known position: wrong direction
        if (!at_open && !at_closed && elapsed < model_cfg.min_run_ticks && w.end_reached) begin
          if (early_cnt != 8'hFF) early_cnt = early_cnt + 8'd1;
          if (early_cnt > model_cfg.wrong_dir_confirm) begin
            halt_run();
            ev = EV_WRONG_DIR;
          end
        end
        if (ev == EV_NONE && elapsed > model_cfg.min_run_ticks && w.end_reached) begin
          if (late_cnt != 8'hFF) late_cnt = late_cnt + 8'd1;
          if (late_cnt > model_cfg.end_confirm) begin
            halt_run();
            ev = EV_DONE;
          end
        end
      end
    end else if (elapsed >= model_cfg.min_gap_ticks) begin
      // light counting, each side clears the other
      if (w.light_level > model_cfg.light_threshold) begin
        day_cnt = '0;
        if (!at_closed) begin
          if (dark_ticks >= model_cfg.light_confirm_ticks) begin
            start_motor(1'b1);
            ev = EV_START_CLOSE;
          end else if (dark_ticks != 8'hFF) begin
            dark_ticks = dark_ticks + 8'd1;
          end
        end
      end else begin
        dark_ticks = '0;
        if (!at_open) begin
          if (day_cnt >= model_cfg.light_confirm_ticks) begin
            start_motor(1'b0);
            ev = EV_START_OPEN;
          end else if (day_cnt != 8'hFF) begin
            day_cnt = day_cnt + 8'd1;
          end
        end
      end
    end

    r.drive_close = motor_on && closing_night;
    r.drive_open  = motor_on && !closing_night;
    r.fault_led   = fault_latched;
    r.event_code  = ev;
    return r;
  endfunction

  // Driver: presents queued words, holds a stalled word, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) expected_results.push_back(curtain_tick(tick_word));
      if (!item_valid || !item_stall) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          tick_word  <= pending_ticks.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result word against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: unexpected result word %p", result_word);
        end else begin
          want = expected_results.pop_front();
          words_checked++;
          if (result_word.event_code < 6) event_seen[result_word.event_code]++;
          if (result_word.drive_close !== want.drive_close ||
              result_word.drive_open !== want.drive_open ||
              result_word.fault_led !== want.fault_led ||
              result_word.event_code !== want.event_code) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("ERROR: word %0d exp cl=%b op=%b led=%b ev=%0d got cl=%b op=%b led=%b ev=%0d",
                       words_checked, want.drive_close, want.drive_open, want.fault_led,
                       want.event_code, result_word.drive_close, result_word.drive_open,
                       result_word.fault_led, result_word.event_code);
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_tick(input int unsigned light, input logic sw);
    item_t w;
    w.light_level = light[7:0];
    w.end_reached = sw;
    pending_ticks.push_back(w);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LIGHT_THRESHOLD: model_cfg.light_threshold     = value[7:0];
      REG_LIGHT_CONFIRM:   model_cfg.light_confirm_ticks = value[7:0];
      REG_MIN_GAP:         model_cfg.min_gap_ticks       = value[15:0];
      REG_MAX_RUN:         model_cfg.max_run_ticks       = value[19:0];
      REG_MIN_RUN:         model_cfg.min_run_ticks       = value[19:0];
      REG_WRONG_DIR:       model_cfg.wrong_dir_confirm   = value[7:0];
      REG_END_CONFIRM:     model_cfg.end_confirm         = value[7:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input int unsigned thr, input int unsigned confirm,
                              input int unsigned gap, input int unsigned max_run,
                              input int unsigned min_run, input int unsigned wrong_dir,
                              input int unsigned end_conf);
    write_reg(REG_LIGHT_THRESHOLD, thr);
    write_reg(REG_LIGHT_CONFIRM, confirm);
    write_reg(REG_MIN_GAP, gap);
    write_reg(REG_MAX_RUN, max_run);
    write_reg(REG_MIN_RUN, min_run);
    write_reg(REG_WRONG_DIR, wrong_dir);
    write_reg(REG_END_CONFIRM, end_conf);
    settings_used++;
  endtask

  // Wait until every queued word is sent and every result is back
  task automatic drain();
    while (pending_ticks.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly whole day/night episodes: a light run long enough to confirm,
  // a motor run, then end-switch presses. The rest is noise or cut-short runs.
  task automatic queue_random_ticks(input int unsigned count);
    int unsigned made, kind, len, k, thr, run_len, hits;
    logic night;
    made = 0;
    thr = model_cfg.light_threshold;
    while (made < count) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        push_tick($urandom_range(255), 1'($urandom_range(1)));
        made++;
      end else begin
        night = (thr == 255) ? 1'b0 : 1'($urandom_range(1));
        len = model_cfg.light_confirm_ticks + 1 + $urandom_range(3) +
              ((model_cfg.min_gap_ticks > 40) ? 40 : model_cfg.min_gap_ticks);
        if (kind < 25) len = $urandom_range(len);
        for (k = 0; k < len; k++)
          push_tick(night ? $urandom_range(255, thr + 1) : $urandom_range(thr, 0),
                    1'($urandom_range(1)));
        run_len = ((model_cfg.min_run_ticks > 30) ? 30 : model_cfg.min_run_ticks) +
                  $urandom_range(2);
        for (k = 0; k < run_len; k++)
          push_tick($urandom_range(255), ($urandom_range(9) == 0));
        hits = model_cfg.end_confirm + 1 + $urandom_range(1);
        if (hits > 8) hits = 8;
        for (k = 0; k < hits; k++)
          push_tick($urandom_range(255), 1'b1);
        made += len + run_len + hits;
      end
    end
  endtask

  // Stimulus and phase sequencing
  initial begin
    model_cfg     = CFG_RESET;
    closing_night = 1'b0;
    motor_on      = 1'b0;
    at_open       = 1'b0;
    at_closed     = 1'b0;
    fault_latched = 1'b0;
    dark_ticks    = '0;
    day_cnt       = '0;
    early_cnt     = '0;
    late_cnt      = '0;
    elapsed       = {TIME_BITS{1'b1}};
    foreach (event_seen[i]) event_seen[i] = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: close then early switch (wrong direction), open then done
    // exactly past the minimum run, with the equal-to-minimum tick in between.
    load_setting(50, 2, 0, 1048575, 6, 1, 0);
    push_tick(255, 1'b1);
    push_tick(255, 1'b0);
    push_tick(255, 1'b0);
    push_tick(0, 1'b1);
    push_tick(128, 1'b1);
    push_tick(51, 1'b0);
    push_tick(50, 1'b1);
    push_tick(0, 1'b0);
    push_tick(0, 1'b0);
    push_tick(0, 1'b1);
    repeat (4) push_tick(200, 1'b0);
    push_tick(255, 1'b1);
    push_tick(0, 1'b1);
    push_tick(255, 1'b0);
    drain();

    // unmapped index must not disturb anything
    write_reg(REG_UNUSED, 20'hFFFFF);

    for (int p = 1; p <= 6; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 74; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 74; end
        default: begin send_gap_pct = 24; recv_stall_pct = 24; end
      endcase
      case (p)
        1: begin load_setting(128, 3, 5, 1048575, 6, 0, 1);    queue_random_ticks(250); end
        2: begin load_setting(0, 0, 0, 100000, 0, 2, 0);       queue_random_ticks(200); end
        3: begin load_setting(200, 10, 30, 50000, 20, 3, 3);   queue_random_ticks(250); end
        4: begin
          load_setting(255, 255, 65535, 1048575, 1048575, 255, 255);
          queue_random_ticks(120);
        end
        5: begin load_setting(90, 1, 2, 1048575, 3, 1, 2);     queue_random_ticks(250); end
        default: begin load_setting(60, 4, 8, 20000, 12, 5, 0); queue_random_ticks(200); end
      endcase
      drain();
    end

    // Last: zero run limit forces a timeout, then the fault holds
    send_gap_pct = 24;
    recv_stall_pct = 24;
    load_setting(50, 0, 0, 0, 30, 0, 0);
    repeat (3) push_tick(255, 1'b0);
    repeat (3) push_tick(0, 1'b0);
    repeat (20) push_tick($urandom_range(255), 1'($urandom_range(1)));
    drain();

    mismatches += expected_results.size();
    $display("Covered %0d result words under %0d register settings with mixed idling.",
             words_checked, settings_used);
    $display("Events: close %0d, open %0d, done %0d, wrong direction %0d, timeout %0d.",
             event_seen[EV_START_CLOSE], event_seen[EV_START_OPEN], event_seen[EV_DONE],
             event_seen[EV_WRONG_DIR], event_seen[EV_TIMEOUT]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
design/lcmc_pkg.sv
design/lcmc_step.sv
design/light_driven_curtain_motor_control.sv
design/lcmc_checker.sv
dv/tb_light_driven_curtain_motor_control.sv
